// ===== hw/rtl/rgds_pkg.sv =====
// ----------------------------------------------------------------------------
// rgds_pkg
// Shared widths, register indexes and reset values for the reset gesture
// drive swap block.
// ----------------------------------------------------------------------------
package rgds_pkg;

    localparam int unsigned SHORT_W  = 16;
    localparam int unsigned LONG_W   = 20;
    localparam int unsigned IDLE_W   = 24;
    localparam int unsigned PRESS_W  = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 24;
    localparam int unsigned TDATA_W  = 8;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx REG_SHORT_MIN = 2'd0;
    localparam t_cfg_idx REG_LONG_MIN  = 2'd1;
    localparam t_cfg_idx REG_IDLE_LIM  = 2'd2;
    localparam t_cfg_idx REG_PRESSES   = 2'd3;

    // Reset values of the configuration registers
    localparam logic [SHORT_W-1:0] SHORT_MIN_RST = 16'd1000;
    localparam logic [LONG_W-1:0]  LONG_MIN_RST  = 20'd50000;
    localparam logic [IDLE_W-1:0]  IDLE_LIM_RST  = 24'd3000000;
    localparam logic [PRESS_W-1:0] PRESSES_RST   = 4'd3;

endpackage

// ===== hw/rtl/reset_gesture_drive_swap_core.sv =====
// ----------------------------------------------------------------------------
// reset_gesture_drive_swap_core
// Swaps two active-low drive selects when the reset line shows a long hold
// or a set number of short presses; the LED shows the swap state.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata[0] reset_n, [1] sel0_n, [2] sel1_n, [7:3] zero
// m_axis    out        tdata[0] led_on, [1] hdr_sel0_n, [2] hdr_sel1_n, [7:3] zero
// cfg       in         i_cfg_we, i_cfg_idx (register index), i_cfg_wdata
//
// One transaction is taken per clock while the output is not stalled; its result
// sits in the output register on the next cycle.
// The sample update is a few compares and increments on the running counters.
// Reset (synchronous, active low) restores the register defaults and clears
// all gesture state and the output valid.
// A stalled output holds its transaction; the input stalls only while a
// result waits untaken.
// ----------------------------------------------------------------------------
module reset_gesture_drive_swap_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Sample stream: [0] reset_n, [1] sel0_n, [2] sel1_n
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rgds_pkg::TDATA_W-1:0]  s_axis_tdata,
    // Result stream: [0] led_on, [1] hdr_sel0_n, [2] hdr_sel1_n
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rgds_pkg::TDATA_W-1:0]  m_axis_tdata,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  rgds_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [rgds_pkg::CFG_DAT_W-1:0] i_cfg_wdata
);
    import rgds_pkg::*;

    // Configuration registers
    logic [SHORT_W-1:0] r_short_min;
    logic [LONG_W-1:0]  r_long_min;
    logic [IDLE_W-1:0]  r_idle_lim;
    logic [PRESS_W-1:0] r_presses;

    // Gesture state
    logic               r_swap;
    logic               r_long_done;
    logic [LONG_W-1:0]  r_low_ticks;
    logic [IDLE_W-1:0]  r_idle_ticks;
    logic [PRESS_W-1:0] r_press_cnt;

    // Next values
    logic               n_swap;
    logic               n_long_done;
    logic [LONG_W-1:0]  n_low_ticks;
    logic [IDLE_W-1:0]  n_idle_ticks;
    logic [PRESS_W-1:0] n_press_cnt;

    // Values after the reset-line handling, before the idle check
    logic [LONG_W-1:0]  w_low_mid;
    logic [IDLE_W-1:0]  w_idle_mid;
    logic [PRESS_W-1:0] w_press_mid;
    logic [PRESS_W-1:0] w_press_inc;
    logic               w_short_press;

    // Output register
    logic               r_out_valid;
    logic [TDATA_W-1:0] r_out_data;

    logic w_in_rst_n;
    logic w_in_sel0_n;
    logic w_in_sel1_n;
    logic w_accept;

    assign w_in_rst_n  = s_axis_tdata[0];
    assign w_in_sel0_n = s_axis_tdata[1];
    assign w_in_sel1_n = s_axis_tdata[2];

    // Take a new sample whenever the output register is free or being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_press_inc   = r_press_cnt + PRESS_W'(1);
    assign w_short_press = (r_low_ticks < r_long_min) &&
                           (r_low_ticks > {{(LONG_W-SHORT_W){1'b0}}, r_short_min});

    always_comb begin
        n_swap      = r_swap;
        n_long_done = r_long_done;
        w_low_mid   = r_low_ticks;
        w_idle_mid  = r_idle_ticks;
        w_press_mid = r_press_cnt;

        if (!w_in_rst_n) begin
            // Line held low: climb toward the long threshold, toggle once per hold
            if (r_low_ticks < r_long_min) begin
                w_low_mid = r_low_ticks + LONG_W'(1);
            end else if (!r_long_done) begin
                n_swap      = !r_swap;
                n_long_done = 1'b1;
            end
            w_idle_mid = '0;
        end else begin
            // Line released: a low time between the thresholds is a short press
            if (w_short_press) begin
                if (w_press_inc == r_presses) begin
                    w_press_mid = '0;
                    n_swap      = !r_swap;
                end else begin
                    w_press_mid = w_press_inc;
                end
            end
            w_low_mid   = '0;
            n_long_done = 1'b0;
        end

        // Idle check sees the idle count as left by the handling above
        n_low_ticks = w_low_mid;
        n_press_cnt = w_press_mid;
        if (w_idle_mid < r_idle_lim) begin
            n_idle_ticks = w_idle_mid + IDLE_W'(1);
        end else begin
            n_idle_ticks = w_idle_mid;
            n_press_cnt  = '0;
            n_low_ticks  = '0;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_min <= SHORT_MIN_RST;
            r_long_min  <= LONG_MIN_RST;
            r_idle_lim  <= IDLE_LIM_RST;
            r_presses   <= PRESSES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SHORT_MIN: r_short_min <= i_cfg_wdata[SHORT_W-1:0];
                REG_LONG_MIN:  r_long_min  <= i_cfg_wdata[LONG_W-1:0];
                REG_IDLE_LIM:  r_idle_lim  <= i_cfg_wdata[IDLE_W-1:0];
                REG_PRESSES:   r_presses   <= i_cfg_wdata[PRESS_W-1:0];
                default: ;
            endcase
        end
    end

    // Gesture state advances once per accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap       <= 1'b0;
            r_long_done  <= 1'b0;
            r_low_ticks  <= '0;
            r_idle_ticks <= '0;
            r_press_cnt  <= '0;
        end else if (w_accept) begin
            r_swap       <= n_swap;
            r_long_done  <= n_long_done;
            r_low_ticks  <= n_low_ticks;
            r_idle_ticks <= n_idle_ticks;
            r_press_cnt  <= n_press_cnt;
        end
    end

    // Output register: load on accept, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {5'b0,
                           n_swap ? w_in_sel0_n : w_in_sel1_n,
                           n_swap ? w_in_sel1_n : w_in_sel0_n,
                           n_swap};
        end
    end

    // The LED bit of a pending result always matches the live swap flag
    a_led_matches_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[0] == r_swap))
        else $error("pending LED bit differs from swap flag");

    // Swap flag moves only with an accepted transaction
    a_swap_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_swap))
        else $error("swap flag changed without a transaction");

    // A released-line sample clears the hold tracking
    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_in_rst_n) |=> (r_low_ticks == '0 && !r_long_done))
        else $error("release did not clear low time");

    // A low-line sample restarts the idle count
    a_low_restarts_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_in_rst_n) |=> (r_idle_ticks <= IDLE_W'(1)))
        else $error("idle count not restarted on low line");

endmodule
